FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

FILE: hw/rtl/dtoi_pkg.sv
// Package for the double to integer converter: widths and rounding codes.
// No dependencies.
package dtoi_pkg;
   localparam int RESULT_BITS = 32;
   localparam logic [1:0] RND_NEAREST = 2'd0;
   localparam logic [1:0] RND_CEIL    = 2'd1;
   localparam logic [1:0] RND_FLOOR   = 2'd2;
endpackage

FILE: hw/rtl/double_to_int_round_convert_top.sv
// Double to integer converter with selectable rounding.
// The start beat is registered in in_vld_ff and then in out_vld_ff, which drives rsp_valid.
// Throughput: one beat per cycle; busy is always low, set by the single-pass datapath.
// Reset: synchronous active-high reset clears valids and round mode (nearest).
// The receiver cannot stall; results appear for exactly one cycle.
// Depends on dtoi_pkg and dtoi_core.
module double_to_int_round_convert_top import dtoi_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [63:0]            req_value_bits,
   input  logic                   csr_write_en,
   input  logic [1:0]             csr_write_data,
   output logic                   rsp_valid,
   output logic [RESULT_BITS-1:0] rsp_int_result,
   output logic                   rsp_domain_error
);
   logic [1:0]  mode_ff;
   logic        in_vld_ff;
   logic [63:0] in_bits_ff;
   logic        out_vld_ff;
   logic [RESULT_BITS-1:0] res_ff, res_in;
   logic        err_ff, err_in;

   // never stalls: one beat per cycle
   assign busy = 1'b0;

   dtoi_core u_core (
      .value_bits   (in_bits_ff),
      .round_mode   (mode_ff),
      .int_result   (res_in),
      .domain_error (err_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= RND_NEAREST;
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (csr_write_en) mode_ff <= csr_write_data;
         in_vld_ff  <= start;
         out_vld_ff <= in_vld_ff;
      end
      // payload registers
      in_bits_ff <= req_value_bits;
      res_ff     <= res_in;
      err_ff     <= err_in;
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_int_result   = res_ff;
   assign rsp_domain_error = err_ff;
endmodule

FILE: hw/rtl/dtoi_core.sv
// Combinational double to integer rounding datapath.
// Depends on dtoi_pkg.
module dtoi_core import dtoi_pkg::*; (
   input  logic [63:0]            value_bits,
   input  logic [1:0]             round_mode,
   output logic [RESULT_BITS-1:0] int_result,
   output logic                   domain_error
);
   logic        neg;
   logic [10:0] expo;
   logic [52:0] mag;
   logic [11:0] sh;      // effective exponent minus 1075, two's complement
   logic [11:0] rs;
   logic [116:0] wide;   // mag placed so integer part is [116:64]
   logic [64:0] ip;
   logic [63:0] frac_part;
   logic        rem_nz, half_up, up, big;
   logic [64:0] ipr, lim;
   logic        err;

   always_comb begin
      neg  = value_bits[63];
      expo = value_bits[62:52];
      mag  = {(expo != 11'd0), value_bits[51:0]};
      sh   = {1'b0, (expo != 11'd0) ? expo : 11'd1} - 12'd1075;
      rs   = 12'd0 - sh;
      big  = !sh[11] && (sh > 12'd11);
      ip   = '0;
      frac_part = '0;
      wide = '0;
      if (!sh[11]) begin
         ip = {12'd0, mag} << sh[3:0];
      end else if (rs > 12'd64) begin
         frac_part = {63'd0, mag != 53'd0}; // tiny, below half
      end else begin
         wide = {mag, 64'd0} >> rs[6:0];
         ip = {12'd0, wide[116:64]};
         frac_part = wide[63:0];
      end
      rem_nz  = frac_part != 64'd0;
      half_up = frac_part[63];
      case (round_mode)
         RND_CEIL:  up = rem_nz && !neg;
         RND_FLOOR: up = rem_nz && neg;
         default:   up = half_up;
      endcase
      ipr = ip + {64'd0, up};
      lim = 65'd1 << (RESULT_BITS - 1);
      err = (expo == 11'h7FF) || big || (neg ? (ipr > lim) : (ipr > lim - 65'd1));
      domain_error = err;
      if (err)
         int_result = '0;
      else if (neg)
         int_result = RESULT_BITS'(65'd0 - ipr);
      else
         int_result = ipr[RESULT_BITS-1:0];
   end
endmodule

FILE: hw/rtl/dtoi_checker.sv
// Port-level checker for the converter, bound to the top level.
// Depends on dtoi_pkg and assert_macros.svh.
`include "assert_macros.svh"
module dtoi_checker import dtoi_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input logic [RESULT_BITS-1:0] rsp_int_result,
   input logic                   rsp_domain_error
);
   `ASSERT_IMPL(a_never_busy, clock, reset, 1'b1, !busy)
   `ASSERT_IMPL(a_err_zero, clock, reset, rsp_valid && rsp_domain_error, rsp_int_result == '0)
   `ASSERT_NEXT(a_latency, clock, reset, start && !busy, 1'b1 ##1 rsp_valid)
   `ASSERT_IMPL(a_no_spurious, clock, reset, rsp_valid && !$past(reset, 2), $past(start, 2))
endmodule

bind double_to_int_round_convert_top dtoi_checker u_dtoi_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_int_result   (rsp_int_result),
   .rsp_domain_error (rsp_domain_error)
);
